// File: rtl/ipbs_pkg.sv
// ----------------------------------------------------------------------------
// ipbs_pkg: shared definitions for the integer power core
// Widths, tdata packing, controller states and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ipbs_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int EXP_BITS    = 31;
  localparam int IN_TDATA_W  = ((DATA_WIDTH + EXP_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [EXP_BITS-1:0]   expo_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new base and exponent
    logic step;     // one square-and-multiply iteration
    logic publish;  // copy the running product to the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ex_zero;  // no exponent bits left to process
  } dp_sts_t;

endpackage

// File: rtl/ipbs_dp.sv
// ----------------------------------------------------------------------------
// ipbs_dp: square-and-multiply datapath
// Holds the running product, the running square of the base and the
// remaining exponent, plus the output result register.
// ----------------------------------------------------------------------------
module ipbs_dp
  import ipbs_pkg::*;
(
  input  logic    clk,
  input  data_t   base_in,
  input  expo_t   expo_in,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output data_t   result
);

  data_t acc;
  data_t pw;
  expo_t ex;
  data_t res;

  data_t sq_prod;
  data_t acc_prod;

  // Both products keep only the low DATA_WIDTH bits, which is the wrap the
  // arithmetic calls for. The two multipliers work side by side.
  assign sq_prod  = pw * pw;
  assign acc_prod = acc * pw;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= (base_in == '0) ? '0 : data_t'(1);
      pw  <= base_in;
      ex  <= expo_in;
    end else if (cmd.step) begin
      pw  <= sq_prod;
      if (ex[0]) begin
        acc <= acc_prod;
      end
      ex  <= ex >> 1;
    end
    if (cmd.publish) begin
      res <= acc;
    end
  end

  assign sts.ex_zero = (ex == '0);
  assign result      = res;

endmodule

// File: rtl/ipbs_ctrl.sv
// ----------------------------------------------------------------------------
// ipbs_ctrl: sequencing controller
// Accepts one transaction at a time, steps the datapath until the exponent
// is used up and manages the valid flag of the output register.
// ----------------------------------------------------------------------------
module ipbs_ctrl
  import ipbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        ovalid;
  logic        ovalid_next;
  logic        out_free;

  assign out_free = !ovalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.ex_zero && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_RUN: begin
        cmd.step    = !sts.ex_zero;
        cmd.publish = sts.ex_zero && out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    ovalid_next = ovalid;
    if (cmd.publish) begin
      ovalid_next = 1'b1;
    end else if (m_tready) begin
      ovalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  assign m_tvalid = ovalid;

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!m_tvalid || m_tready))
    else $error("result published over an untaken result");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> m_tvalid)
    else $error("published result not shown as valid");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (s_tready && !cmd.step && !cmd.publish))
    else $error("load issued outside idle");

  a_step_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !sts.ex_zero)
    else $error("step issued with no exponent bits left");

endmodule

// File: rtl/integer_power_by_squaring_core.sv
// ----------------------------------------------------------------------------
// integer_power_by_squaring_core: signed integer power by squaring
// Raises a signed base to a non-negative exponent with products wrapped
// modulo 2^DATA_WIDTH, over streaming slave and master interfaces.
// ----------------------------------------------------------------------------
// The core computes base_value ** exponent_value, wrapping every product
// modulo 2^DATA_WIDTH as two's complement. A zero base yields 0 for every
// exponent, including 0; any other base with a zero exponent yields 1. The
// exponent is scanned from its least significant bit: every iteration squares
// the running power of the base and, when the current bit is one, multiplies
// it into the running product, so the two multipliers work in parallel and
// one exponent bit retires per clock. The iteration loop sets the rate: a new
// transaction is accepted only once the result of the previous one has been
// published. One transaction is worked on at a time. The result sits in its own
// output register, so the next transaction is accepted while a finished
// result still waits on m_tready; a stalled output only holds the core once a
// second result is ready.
module integer_power_by_squaring_core
  import ipbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // tdata fields, lowest bit up: base_value, exponent_value, zero fill.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // tdata fields, lowest bit up: power_result, zero fill.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  data_t   base_in;
  expo_t   expo_in;
  data_t   result;

  // Unpack the slave tdata; any fill bits above the exponent are ignored.
  assign base_in = s_tdata[DATA_WIDTH-1:0];
  assign expo_in = s_tdata[DATA_WIDTH+EXP_BITS-1:DATA_WIDTH];

  ipbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipbs_dp u_dp (
    .clk     (clk),
    .base_in (base_in),
    .expo_in (expo_in),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

  // Zero-extend the result to whole bytes.
  assign m_tdata = OUT_TDATA_W'(result);

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for integer_power_by_squaring_core
// Streams signed bases and exponents through the core. A bursty source and
// a sink with its own stall pattern surround it, and every result is checked
// against a square-and-multiply predictor in arrival order.
// ----------------------------------------------------------------------------
module tb;
  import ipbs_pkg::*;

  // One pending input transaction. When wait_idle is set, the source holds
  // the item back until every earlier result has been returned.
  typedef struct {
    data_t base;
    expo_t expo;
    logic  wait_idle;
  } power_req_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  power_req_t pending_reqs[$];
  data_t      expected_powers[$];

  int total_reqs = 0;
  int accepted_cnt = 0;  // input transactions taken by the core
  int returned_cnt = 0;  // result transactions taken by the sink
  int err_count = 0;
  int zero_base_cnt = 0;
  int zero_expo_cnt = 0;

  // Source burst state, touched only by the driver process.
  int burst_left = 1;
  int gap_left = 0;

  // Sink stall pattern state, touched only by the sink process.
  int sink_mode = 0;
  int sink_period_left = 0;
  int sink_phase = 0;

  integer_power_by_squaring_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected power: scan the exponent from the top bit down, squaring the
  // running product every bit and folding in the base on a one. All products
  // are truncated to DATA_WIDTH bits, which gives two's complement wrapping.
  // A zero base is forced to zero, even for a zero exponent.
  function automatic data_t power_of(data_t base, expo_t expo);
    data_t acc;
    acc = data_t'(1);
    if (base == '0) return '0;
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = acc * acc;
      if (expo[i]) acc = acc * base;
    end
    return acc;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("tb: mismatch %0d at %0t: %s", err_count, $realtime, msg);
  endtask

  task automatic add_req(data_t base, expo_t expo, logic wait_idle);
    power_req_t r;
    r.base = base;
    r.expo = expo;
    r.wait_idle = wait_idle;
    pending_reqs.push_back(r);
    if (base == '0) zero_base_cnt++;
    if (expo == '0) zero_expo_cnt++;
  endtask

  // Source: presents items from the pending queue in bursts of random
  // length separated by random idle gaps. A new item is chosen only when
  // the slot is free, so tvalid never drops while an item is still offered.
  always @(posedge clk) begin : drive_proc
    power_req_t nxt;
    logic       go;
    go = 1'b0;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        // Counters are sampled before this edge, so a transaction taken at
        // this edge is not in them yet and is checked separately.
        if (!pending_reqs[0].wait_idle ||
            (accepted_cnt == returned_cnt && !(s_tvalid && s_tready))) begin
          nxt = pending_reqs.pop_front();
          go = 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            // A quarter of the bursts follow straight on with no gap.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
      s_tvalid <= go;
      if (go) s_tdata <= {{(IN_TDATA_W - DATA_WIDTH - EXP_BITS){1'b0}}, nxt.expo, nxt.base};
    end
  end

  // Sink: picks a stall pattern for a random stretch of cycles. Mode 0 is
  // always ready, mode 1 is a coin toss per cycle, mode 2 is a fixed on/off
  // cycle and mode 3 holds tready low for long stretches.
  always @(posedge clk) begin : sink_proc
    logic rdy;
    rdy = 1'b1;
    if (sink_period_left == 0) begin
      sink_mode = $urandom_range(0, 3);
      sink_period_left = $urandom_range(16, 200);
      sink_phase = 0;
    end else begin
      sink_period_left = sink_period_left - 1;
    end
    sink_phase = sink_phase + 1;
    case (sink_mode)
      0: rdy = 1'b1;
      1: rdy = 1'($urandom_range(0, 1));
      2: rdy = (sink_phase % 7) < 3;
      default: rdy = (sink_phase % 40) >= 30;
    endcase
    m_tready <= rdy;
  end

  // Monitor: checks each returned result against the oldest expectation,
  // then records the expectation for any input taken at the same edge. A
  // result never leaves in the cycle its input arrives, so this order holds.
  always @(posedge clk) begin : monitor_proc
    data_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_powers.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", m_tdata));
        end else begin
          want = expected_powers.pop_front();
          if (m_tdata[DATA_WIDTH-1:0] !== want)
            report_mismatch($sformatf("power_result got %h expected %h",
                                      m_tdata[DATA_WIDTH-1:0], want));
        end
        returned_cnt <= returned_cnt + 1;
      end
      if (s_tvalid && s_tready) begin
        expected_powers.push_back(power_of(s_tdata[DATA_WIDTH-1:0],
                                           s_tdata[DATA_WIDTH+EXP_BITS-1:DATA_WIDTH]));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : main_proc
    data_t b;
    expo_t e;
    int    sel;

    // Directed: zero base, zero exponent, unit and sign bases, wrapping.
    add_req(32'h0000_0000, 31'd0, 1'b0);
    add_req(32'h0000_0000, 31'h7FFF_FFFF, 1'b0);
    add_req(32'h0000_0000, 31'd5, 1'b0);
    add_req(32'h0000_0001, 31'd0, 1'b0);
    add_req(32'hFFFF_FFFF, 31'd0, 1'b0);
    add_req(32'h8000_0000, 31'd0, 1'b0);
    add_req(32'h0000_0001, 31'h7FFF_FFFF, 1'b0);
    add_req(32'hFFFF_FFFF, 31'd1, 1'b0);
    add_req(32'hFFFF_FFFF, 31'd2, 1'b0);
    add_req(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    add_req(32'hFFFF_FFFF, 31'h7FFF_FFFE, 1'b0);
    add_req(32'h0000_0002, 31'd30, 1'b0);
    add_req(32'h0000_0002, 31'd31, 1'b0);
    add_req(32'h0000_0002, 31'd32, 1'b0);
    add_req(32'h0000_0003, 31'd20, 1'b0);
    add_req(32'hFFFF_FFFD, 31'd3, 1'b0);
    add_req(32'h8000_0000, 31'd1, 1'b0);
    add_req(32'h8000_0000, 31'd2, 1'b0);
    add_req(32'h7FFF_FFFF, 31'd2, 1'b0);
    add_req(32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    add_req(32'h0000_0007, 31'd1, 1'b0);
    add_req(32'hDEAD_BEEF, 31'h4000_0000, 1'b0);
    add_req(32'h1234_5679, 31'h5555_5555, 1'b0);
    add_req(32'hA5A5_A5A5, 31'h2AAA_AAAA, 1'b0);

    // Random part. Two items are held until the core has fully drained.
    for (int n = 0; n < 600; n++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: b = '0;
        1: begin
          case ($urandom_range(0, 5))
            0: b = 32'h0000_0001;
            1: b = 32'hFFFF_FFFF;
            2: b = 32'h0000_0002;
            3: b = 32'hFFFF_FFFE;
            4: b = 32'h8000_0000;
            default: b = 32'h7FFF_FFFF;
          endcase
        end
        2, 3, 4, 5: b = data_t'($urandom_range(0, 32)) - data_t'(16);
        default: b = $urandom();
      endcase
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3, 4, 5: e = expo_t'($urandom_range(0, 40));
        6: e = expo_t'(1) << $urandom_range(0, EXP_BITS - 1);
        7: e = 31'h7FFF_FFFF - expo_t'($urandom_range(0, 7));
        default: e = expo_t'($urandom());
      endcase
      add_req(b, e, (n == 0) || (n == 300));
    end
    total_reqs = pending_reqs.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait until every item has been taken, then until every result is back,
    // then let the core run past its longest latency.
    while (accepted_cnt != total_reqs) @(posedge clk);
    while (returned_cnt != accepted_cnt) @(posedge clk);
    repeat (40) @(posedge clk);

    if (expected_powers.size() != 0)
      report_mismatch($sformatf("%0d results never returned", expected_powers.size()));

    $display("Covered %0d power computations: %0d zero bases, %0d zero exponents,",
             returned_cnt, zero_base_cnt, zero_expo_cnt);
    $display("bursty source, patterned sink stalls and two full drains.");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog_proc
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/ipbs_pkg.sv
rtl/ipbs_dp.sv
rtl/ipbs_ctrl.sv
rtl/integer_power_by_squaring_core.sv
dv/tb.sv
